/* hdl/bpc_pkg.sv */
// Shared types and constants for the button press classifier.
package bpc_pkg;

  localparam int CNT_W    = 16;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [CNT_W-1:0] HOLD_THRESHOLD_RST  = CNT_W'(2000);
  localparam logic [CNT_W-1:0] RELEASE_TIMEOUT_RST = CNT_W'(500);

  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIMEOUT = CFG_IDX_W'(1);

  localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SINGLE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ALT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LONG   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NONE   = 3'd4;

  localparam logic [MODE_W-1:0] LOCK_TOGGLED = 2'd0;
  localparam logic [MODE_W-1:0] LOCK_ARMED   = 2'd1;
  localparam logic [MODE_W-1:0] LOCK_INIT    = 2'd2;

  localparam logic [MODE_W-1:0] PRESS_NONE  = 2'd0;
  localparam logic [MODE_W-1:0] PRESS_SHORT = 2'd1;
  localparam logic [MODE_W-1:0] PRESS_LONG  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0]    hold_count;
    logic                toggle_bit;
    logic [MODE_W-1:0]   lock_mode;
    logic [MODE_W-1:0]   press_mode;
    logic [CNT_W-1:0]    release_count;
    logic [STATUS_W-1:0] last_status;
  } bpc_state_t;

  localparam bpc_state_t STATE_RST = '{
    hold_count:    '0,
    toggle_bit:    1'b0,
    lock_mode:     LOCK_INIT,
    press_mode:    PRESS_NONE,
    release_count: '0,
    last_status:   ST_IDLE
  };

endpackage

/* hdl/button_press_classifier_top.sv */
// Top level of the button press classifier.
// Each input word is one sampled key level (0 pressed, 1 released) and yields
// exactly one status word, registered in the cycle after it is accepted. A new
// word can be accepted in every cycle in which the output register is empty or its
// status is taken by out_ready in the same cycle; while a status waits for out_ready
// the input stalls. The single output register sets the rate of one word per cycle
// while out_ready keeps taking the status. The hold threshold and release timeout
// registers are written through the configuration channel, which is always ready.
module button_press_classifier_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              key_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpc_pkg::STATUS_W-1:0]      press_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CNT_W-1:0]         cfg_data
);

  logic [bpc_pkg::CNT_W-1:0] hold_threshold;
  logic [bpc_pkg::CNT_W-1:0] release_timeout;
  bpc_pkg::bpc_state_t       state;
  bpc_pkg::bpc_state_t       state_next;
  logic                      in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  bpc_step u_step (
    .cur             (state),
    .key_level       (key_level),
    .hold_threshold  (hold_threshold),
    .release_timeout (release_timeout),
    .nxt             (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_threshold  <= bpc_pkg::HOLD_THRESHOLD_RST;
      release_timeout <= bpc_pkg::RELEASE_TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpc_pkg::REG_HOLD_THRESHOLD:  hold_threshold  <= cfg_data;
        bpc_pkg::REG_RELEASE_TIMEOUT: release_timeout <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpc_pkg::STATE_RST;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      press_status <= state_next.last_status;
    end
  end

endmodule

/* hdl/bpc_step.sv */
// Next-state and status logic for one sampled key word.
module bpc_step (
  input  bpc_pkg::bpc_state_t          cur,
  input  logic                         key_level,
  input  logic [bpc_pkg::CNT_W-1:0]    hold_threshold,
  input  logic [bpc_pkg::CNT_W-1:0]    release_timeout,
  output bpc_pkg::bpc_state_t          nxt
);

  logic [bpc_pkg::CNT_W-1:0] hold_inc;
  logic [bpc_pkg::CNT_W-1:0] rel_inc;
  logic                      rel_done;

  assign hold_inc = (cur.hold_count == bpc_pkg::CNT_MAX) ? cur.hold_count
                                                         : cur.hold_count + 1'b1;
  assign rel_inc  = (cur.release_count == bpc_pkg::CNT_MAX) ? cur.release_count
                                                            : cur.release_count + 1'b1;
  assign rel_done = (rel_inc >= release_timeout);

  always_comb begin
    nxt = cur;
    if (!key_level) begin
      nxt.hold_count  = hold_inc;
      nxt.last_status = bpc_pkg::ST_IDLE;
      nxt.press_mode  = bpc_pkg::PRESS_SHORT;
      if (cur.lock_mode == bpc_pkg::LOCK_ARMED) begin
        nxt.toggle_bit    = ~cur.toggle_bit;
        nxt.release_count = '0;
        nxt.lock_mode     = bpc_pkg::LOCK_TOGGLED;
      end
      if (hold_inc > hold_threshold) begin
        nxt.press_mode = bpc_pkg::PRESS_LONG;
      end
    end else begin
      case (cur.press_mode)
        bpc_pkg::PRESS_SHORT: begin
          nxt.lock_mode     = bpc_pkg::LOCK_ARMED;
          nxt.hold_count    = '0;
          nxt.last_status   = cur.toggle_bit ? bpc_pkg::ST_ALT : bpc_pkg::ST_SINGLE;
          nxt.release_count = rel_inc;
          if (rel_done) begin
            nxt.press_mode    = bpc_pkg::PRESS_NONE;
            nxt.release_count = '0;
          end
        end
        bpc_pkg::PRESS_LONG: begin
          nxt.last_status   = bpc_pkg::ST_LONG;
          nxt.release_count = rel_inc;
          if (rel_done) begin
            nxt.hold_count    = '0;
            nxt.press_mode    = bpc_pkg::PRESS_NONE;
            nxt.release_count = '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (nxt.press_mode == bpc_pkg::PRESS_NONE) begin
      nxt.last_status = bpc_pkg::ST_NONE;
    end
  end

endmodule
